>>> src/shb_pkg.sv
package shb_pkg;

    localparam int BUCKET_INDEX_BITS = 24;
    localparam int KEY_BITS          = 8;
    localparam int HASH_BITS         = 64;
    localparam int SEED_BITS         = 32;
    localparam int CFG_DATA_BITS     = (SEED_BITS > BUCKET_INDEX_BITS) ? SEED_BITS
                                                                       : BUCKET_INDEX_BITS;
    localparam int CFG_INDEX_BITS    = 1;
    localparam int NIBBLE_BITS       = 4;
    localparam int HIGH_NIBBLE_SHIFT = 28;
    localparam int STEP_SHIFT        = 4;
    localparam int MIN_BUCKETS       = 13;
    localparam int PRODUCT_BITS      = NIBBLE_BITS + 1 + KEY_BITS + 1;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QUEUE_PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int STEP_COUNT_BITS   = $clog2(HASH_BITS);

    localparam logic [CFG_INDEX_BITS-1:0] REG_HASH_SEED    = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BUCKET_COUNT = 1'd1;

    typedef logic [BUCKET_INDEX_BITS-1:0] bucket_t;
    typedef logic [HASH_BITS-1:0]         hash_t;
    typedef logic [KEY_BITS-1:0]          key_t;
    typedef logic [SEED_BITS-1:0]         seed_t;

    typedef struct packed {
        hash_t   hash;
        bucket_t divisor;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    function automatic hash_t mix_byte(hash_t h, key_t c);
        logic [NIBBLE_BITS:0]    g;
        logic [PRODUCT_BITS-1:0] p;
        begin
            g = {1'b0, h[HIGH_NIBBLE_SHIFT +: NIBBLE_BITS]} + (NIBBLE_BITS+1)'(1);
            p = PRODUCT_BITS'(g) * PRODUCT_BITS'(c) + PRODUCT_BITS'(1);
            mix_byte = (h << STEP_SHIFT) ^ HASH_BITS'(p);
        end
    endfunction

    function automatic bucket_t effective_buckets(bucket_t n);
        bucket_t odd;
        begin
            odd = n | bucket_t'(1);
            if (odd < bucket_t'(MIN_BUCKETS))
                effective_buckets = bucket_t'(MIN_BUCKETS);
            else
                effective_buckets = odd;
        end
    endfunction

endpackage

>>> src/shb_key_if.sv
interface shb_key_if;
    logic          valid;
    logic          ready;
    shb_pkg::key_t key_byte;

    modport source (output valid, output key_byte, input ready);
    modport sink   (input valid, input key_byte, output ready);
endinterface

>>> src/shb_result_if.sv
interface shb_result_if;
    logic             valid;
    logic             ready;
    shb_pkg::bucket_t bucket_index;
    shb_pkg::hash_t   hash_value;

    modport source (output valid, output bucket_index, output hash_value, input ready);
    modport sink   (input valid, input bucket_index, input hash_value, output ready);
endinterface

>>> src/seeded_string_hash_bucket.sv
// Seeded string hash with bucket reduction. Key bytes enter on the key channel at one
// word per cycle while the queue is not full; a zero byte closes the key and yields one
// result word with the 64-bit hash and its remainder modulo the bucket count (forced
// odd, at least 13). The byte update is combinational in the front end and registered
// in the hash register; each closed key then goes through a two-entry queue to a
// bit-serial remainder unit that works on one key at a time and takes the next only
// after moving its result to the result register. Input stalls on every byte while the
// queue is full, so short keys are limited by the remainder unit. A new seed takes
// effect at the next key start and a new bucket count at the next key end.
module seeded_string_hash_bucket (
    input  logic                                clk,
    input  logic                                rst_n,
    shb_key_if.sink                             key,
    shb_result_if.source                        result,
    input  logic                                cfg_we,
    input  logic [shb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [shb_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    shb_pkg::push_t push;
    shb_pkg::job_t  pop_job;
    logic           queue_full;
    logic           pop_valid;
    logic           pop;

    shb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .key_valid  (key.valid),
        .key_byte   (key.key_byte),
        .key_ready  (key.ready),
        .queue_full (queue_full),
        .push       (push)
    );

    shb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (queue_full),
        .pop_valid (pop_valid),
        .pop_job   (pop_job),
        .pop       (pop)
    );

    shb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job       (pop_job),
        .job_pop   (pop),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_index (result.bucket_index),
        .out_hash  (result.hash_value)
    );

endmodule

>>> src/shb_front.sv
module shb_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [shb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [shb_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                key_valid,
    input  shb_pkg::key_t                       key_byte,
    output logic                                key_ready,
    input  logic                                queue_full,
    output shb_pkg::push_t                      push
);

    shb_pkg::seed_t   seed_reg;
    shb_pkg::bucket_t bucket_count_reg;
    shb_pkg::hash_t   hash_reg;
    shb_pkg::hash_t   hash_next;
    shb_pkg::hash_t   hash_start;
    logic             inside_key_reg;
    logic             inside_key_next;
    logic             accept;

    assign key_ready = !queue_full;
    assign accept    = key_valid && key_ready;

    always_comb
    begin
        hash_start = inside_key_reg ? hash_reg : shb_pkg::HASH_BITS'(seed_reg);
        hash_next  = hash_reg;
        inside_key_next = inside_key_reg;
        push.valid = 1'b0;
        push.job.hash = hash_start;
        push.job.divisor = shb_pkg::effective_buckets(bucket_count_reg);
        if (accept)
        begin
            if (key_byte != shb_pkg::key_t'(0))
            begin
                hash_next = shb_pkg::mix_byte(hash_start, key_byte);
                inside_key_next = 1'b1;
            end
            else
            begin
                push.valid = 1'b1;
                inside_key_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg         <= '0;
            bucket_count_reg <= shb_pkg::bucket_t'(shb_pkg::MIN_BUCKETS);
            hash_reg         <= '0;
            inside_key_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    shb_pkg::REG_HASH_SEED:
                        seed_reg <= cfg_data[shb_pkg::SEED_BITS-1:0];
                    shb_pkg::REG_BUCKET_COUNT:
                        bucket_count_reg <= cfg_data[shb_pkg::BUCKET_INDEX_BITS-1:0];
                    default: ;
                endcase
            end
            hash_reg       <= hash_next;
            inside_key_reg <= inside_key_next;
        end
    end

endmodule

>>> src/shb_queue.sv
module shb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  shb_pkg::push_t push,
    output logic           full,
    output logic           pop_valid,
    output shb_pkg::job_t  pop_job,
    input  logic           pop
);

    shb_pkg::job_t                         entry_reg [shb_pkg::QUEUE_DEPTH];
    logic [shb_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_reg;
    logic [shb_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr_reg;
    logic [shb_pkg::QUEUE_CNT_BITS-1:0]    count_reg;
    logic                                  do_push;
    logic                                  do_pop;

    assign full      = count_reg == shb_pkg::QUEUE_CNT_BITS'(shb_pkg::QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_job   = entry_reg[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop && pop_valid;

    function automatic logic [shb_pkg::QUEUE_PTR_BITS-1:0] bump(
        logic [shb_pkg::QUEUE_PTR_BITS-1:0] p);
        begin
            if (p == shb_pkg::QUEUE_PTR_BITS'(shb_pkg::QUEUE_DEPTH - 1))
                bump = '0;
            else
                bump = p + shb_pkg::QUEUE_PTR_BITS'(1);
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push.job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + shb_pkg::QUEUE_CNT_BITS'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - shb_pkg::QUEUE_CNT_BITS'(1);
        end
    end

endmodule

>>> src/shb_back.sv
module shb_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  shb_pkg::job_t     job,
    output logic              job_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output shb_pkg::bucket_t  out_index,
    output shb_pkg::hash_t    out_hash
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                             state_reg;
    logic [1:0]                             state_next;
    logic [shb_pkg::STEP_COUNT_BITS-1:0]    step_reg;
    shb_pkg::hash_t                         dividend_reg;
    shb_pkg::bucket_t                       divisor_reg;
    shb_pkg::bucket_t                       rem_reg;
    shb_pkg::bucket_t                       rem_next;
    logic [shb_pkg::BUCKET_INDEX_BITS:0]    trial;
    logic                                   out_valid_reg;
    shb_pkg::bucket_t                       out_index_reg;
    shb_pkg::hash_t                         out_hash_reg;
    logic                                   hand_off;

    assign trial = {rem_reg, dividend_reg[shb_pkg::HASH_BITS-1]};

    always_comb
    begin
        if (trial >= {1'b0, divisor_reg})
            rem_next = shb_pkg::bucket_t'(trial - {1'b0, divisor_reg});
        else
            rem_next = trial[shb_pkg::BUCKET_INDEX_BITS-1:0];
    end

    assign job_pop  = (state_reg == ST_IDLE) && job_valid;
    assign hand_off = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (job_valid)
                    state_next = ST_RUN;
            ST_RUN:
                if (step_reg == shb_pkg::STEP_COUNT_BITS'(shb_pkg::HASH_BITS - 1))
                    state_next = ST_DONE;
            ST_DONE:
                if (hand_off)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            dividend_reg <= job.hash;
            divisor_reg  <= job.divisor;
            rem_reg      <= '0;
        end
        else if (state_reg == ST_RUN)
        begin
            dividend_reg <= {dividend_reg[shb_pkg::HASH_BITS-2:0],
                             dividend_reg[shb_pkg::HASH_BITS-1]};
            rem_reg      <= rem_next;
        end
        if (hand_off)
        begin
            out_index_reg <= rem_reg;
            out_hash_reg  <= dividend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (job_pop)
                step_reg <= '0;
            else if (state_reg == ST_RUN)
                step_reg <= step_reg + shb_pkg::STEP_COUNT_BITS'(1);
            if (hand_off)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_hash  = out_hash_reg;

endmodule

>>> src/shb_checker.sv
module shb_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                key_valid,
    input  logic                                key_ready,
    input  shb_pkg::key_t                       key_byte,
    input  logic                                result_valid,
    input  logic                                result_ready,
    input  shb_pkg::bucket_t                    bucket_index,
    input  shb_pkg::hash_t                      hash_value,
    input  logic                                cfg_we,
    input  logic [shb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [shb_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    logic [2:0]       pending_reg;
    shb_pkg::bucket_t bucket_count_reg;
    logic             key_end;
    logic             result_take;

    assign key_end     = key_valid && key_ready && key_byte == shb_pkg::key_t'(0);
    assign result_take = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg      <= '0;
            bucket_count_reg <= shb_pkg::bucket_t'(shb_pkg::MIN_BUCKETS);
        end
        else
        begin
            if (key_end && !result_take)
                pending_reg <= pending_reg + 3'd1;
            else if (result_take && !key_end)
                pending_reg <= pending_reg - 3'd1;
            if (cfg_we && cfg_index == shb_pkg::REG_BUCKET_COUNT)
                bucket_count_reg <= cfg_data[shb_pkg::BUCKET_INDEX_BITS-1:0];
        end
    end

    a_result_has_key: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 3'd0)
        else $error("result word without a closed key");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("more closed keys outstanding than the block can hold");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> bucket_index < shb_pkg::effective_buckets(bucket_count_reg))
        else $error("bucket index not below bucket count");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(hash_value))
        else $error("stalled result word changed");

endmodule

bind seeded_string_hash_bucket shb_checker u_shb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .key_valid    (key.valid),
    .key_ready    (key.ready),
    .key_byte     (key.key_byte),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .bucket_index (result.bucket_index),
    .hash_value   (result.hash_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
);
